FILE: hw/rtl/lru_key_value_cache_core_macros.svh
// ------------------------------------------------------------------
// lru key-value cache assertion macros
// concurrent checks that drop out of synthesis builds
// ------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LKVC_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("lkvc check failed");
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc check failed");
`else
`define LKVC_ASSERT(label, expr)
`define LKVC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/lkvc_pkg.sv
// ------------------------------------------------------------------
// lkvc_pkg
// shared widths and entry layout of the lru key-value cache
// ------------------------------------------------------------------
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int AGE_W       = $clog2(MAX_ENTRIES);
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [0:0] OP_GET = 1'b0;
  localparam logic [0:0] OP_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [AGE_W-1:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/lkvc_ram.sv
// ------------------------------------------------------------------
// lkvc_ram
// simple dual-port ram, one write and one registered read per cycle
// ------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/lru_key_value_cache_core.sv
// ------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value store with lru replacement
// ------------------------------------------------------------------
// input channel: in_valid/in_stall carry one word (operation, key,
// put_value); a get returns the stored value on a hit or all ones on a
// miss, a put returns zero; out_hit tells whether the key was present.
// output channel: out_valid/out_stall, one result word per input word.
// the entries live in one 16-deep ram; each word takes a search pass
// over all entries (one read per cycle) and, unless it is a get miss,
// an update pass that ages entries and writes the target slot, then
// posts the result from the done state and returns to idle, where the
// next word is accepted. the single ram read port is why each pass
// reads the entries one at a time.
// a new word is taken while the previous result still waits on a
// stalled receiver; the finished result then holds until the output
// register frees up.
// reset (rst_n low, synchronous) empties the store and sets capacity
// to 16. cfg_wr_en writes capacity and empties the store; write it only
// while the block is idle.
// ------------------------------------------------------------------
`include "lru_key_value_cache_core_macros.svh"

module lru_key_value_cache_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic signed [lkvc_pkg::KEY_W-1:0]   in_key,
  input  logic signed [lkvc_pkg::VAL_W-1:0]   in_put_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic signed [lkvc_pkg::VAL_W-1:0]   out_read_value
);

  import lkvc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic [OCC_W-1:0]       occ_r, occ_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;

  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic [OCC_W-1:0] cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic [AGE_W-1:0] fage_r, fage_nxt;
  logic [VAL_W-1:0] fval_r, fval_nxt;
  logic             free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             lru_ok_r, lru_ok_nxt;
  logic [IDX_W-1:0] lru_idx_r, lru_idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [OCC_W-1:0] limit_r, limit_nxt;

  logic             res_hit_r, res_hit_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_val_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic [OCC_W-1:0] cap_use;
  logic             in_fire;
  logic             out_free;
  logic             rd_valid_bit;

  assign ram_rdata = entry_t'(ram_rbits);

  lkvc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ENTRY_W'(ram_wdata)),
    .rd_en   (ram_re),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (ram_rbits)
  );

  always_comb begin
    if (cap_r == '0) begin
      cap_use = OCC_W'(1);
    end else if (OCC_W'(cap_r) > OCC_W'(MAX_ENTRIES)) begin
      cap_use = OCC_W'(MAX_ENTRIES);
    end else begin
      cap_use = OCC_W'(cap_r);
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign in_fire      = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign rd_valid_bit = valid_r[rd_idx_r];

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = cnt_r[IDX_W-1:0];
    found_nxt    = found_r;
    fidx_nxt     = fidx_r;
    fage_nxt     = fage_r;
    fval_nxt     = fval_r;
    free_ok_nxt  = free_ok_r;
    free_idx_nxt = free_idx_r;
    lru_ok_nxt   = lru_ok_r;
    lru_idx_nxt  = lru_idx_r;
    slot_nxt     = slot_r;
    limit_nxt    = limit_r;
    res_hit_nxt  = res_hit_r;
    res_val_nxt  = res_val_r;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = rd_idx_r;
    ram_wdata    = ram_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt   = S_SCAN;
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          lru_ok_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        if (!cnt_r[IDX_W]) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + OCC_W'(1);
        end
        if (rd_vld_r) begin
          if (rd_valid_bit && ram_rdata.key == key_r && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = rd_idx_r;
            fage_nxt  = ram_rdata.age;
            fval_nxt  = ram_rdata.value;
          end
          if (!rd_valid_bit && !free_ok_r) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (rd_valid_bit && !lru_ok_r
              && (OCC_W'(ram_rdata.age) + OCC_W'(1)) >= occ_r) begin
            lru_ok_nxt  = 1'b1;
            lru_idx_nxt = rd_idx_r;
          end
          if (rd_idx_r == IDX_W'(MAX_ENTRIES - 1)) begin
            // search done: pick the slot to promote, or finish a get miss
            cnt_nxt = '0;
            if (found_nxt) begin
              slot_nxt    = fidx_nxt;
              limit_nxt   = OCC_W'(fage_nxt);
              res_hit_nxt = 1'b1;
              res_val_nxt = (op_r == OP_GET) ? fval_nxt : '0;
              state_nxt   = S_UPD;
            end else if (op_r == OP_GET) begin
              res_hit_nxt = 1'b0;
              res_val_nxt = '1;
              state_nxt   = S_DONE;
            end else begin
              res_hit_nxt = 1'b0;
              res_val_nxt = '0;
              limit_nxt   = OCC_W'(MAX_ENTRIES);
              state_nxt   = S_UPD;
              if (occ_r >= cap_use) begin
                slot_nxt = lru_idx_nxt;
              end else begin
                slot_nxt = free_idx_nxt;
                occ_nxt  = occ_r + OCC_W'(1);
              end
            end
          end
        end
      end
      S_UPD: begin
        if (!cnt_r[IDX_W]) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + OCC_W'(1);
        end
        if (rd_vld_r) begin
          // write back entry read last cycle; next read is another address
          if (rd_idx_r == slot_r) begin
            ram_we        = 1'b1;
            ram_wdata.age = '0;
            if (!found_r) begin
              ram_wdata.key = key_r;
            end
            if (op_r == OP_PUT) begin
              ram_wdata.value = val_r;
            end
          end else if (rd_valid_bit && OCC_W'(ram_rdata.age) < limit_r) begin
            ram_we        = 1'b1;
            ram_wdata.age = ram_rdata.age + AGE_W'(1);
          end
          if (rd_idx_r == IDX_W'(MAX_ENTRIES - 1)) begin
            valid_nxt[slot_r] = 1'b1;
            state_nxt         = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      valid_nxt = '0;
      occ_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      valid_r  <= valid_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wdata;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_put_value;
    end
    if (state_r == S_DONE && out_free) begin
      out_hit_r <= res_hit_r;
      out_val_r <= res_val_r;
    end
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    found_r    <= found_nxt;
    fidx_r     <= fidx_nxt;
    fage_r     <= fage_nxt;
    fval_r     <= fval_nxt;
    free_ok_r  <= free_ok_nxt;
    free_idx_r <= free_idx_nxt;
    lru_ok_r   <= lru_ok_nxt;
    lru_idx_r  <= lru_idx_nxt;
    slot_r     <= slot_nxt;
    limit_r    <= limit_nxt;
    res_hit_r  <= res_hit_nxt;
    res_val_r  <= res_val_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

  // occupancy counts the new slot one pass before its valid bit is set
  `LKVC_ASSERT(a_occ_matches_valid, state_r == S_UPD || $countones(valid_r) == occ_r)
  `LKVC_ASSERT(a_occ_le_cap, state_r != S_IDLE || occ_r <= cap_use || $past(cfg_wr_en))
  `LKVC_ASSERT_NEXT(a_accept_starts_scan, in_fire && !cfg_wr_en, state_r == S_SCAN)

endmodule

FILE: test/lru_key_value_cache_core_test.sv
// ------------------------------------------------------------------
// lru_key_value_cache_core_test
// drives gets and puts through the lru cache under several capacity
// settings and idle patterns, and checks every result word against a
// behavioral lru store kept in the testbench
// ------------------------------------------------------------------
module lru_key_value_cache_core_test;
  import lkvc_pkg::*;

  typedef struct {
    logic [0:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } op_word_t;

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] rdata;
  } lookup_result_t;

  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [VAL_W-1:0] in_put_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [VAL_W-1:0] out_read_value;

  lru_key_value_cache_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_key(in_key), .in_put_value(in_put_value), .out_valid(out_valid),
    .out_stall(out_stall), .out_hit(out_hit), .out_read_value(out_read_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // behavioral store
  logic [KEY_W-1:0] mkey [MAX_ENTRIES];
  logic [VAL_W-1:0] mval [MAX_ENTRIES];
  logic             mvld [MAX_ENTRIES];
  int unsigned      mage [MAX_ENTRIES];
  int unsigned      mocc;
  logic [CAP_W-1:0] mcap;

  op_word_t       pending_words[$];
  lookup_result_t expected_results[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  failed = 0;
  longint cycles = 0;

  function automatic void empty_store();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      mvld[i] = 1'b0;
      mage[i] = 0;
    end
    mocc = 0;
  endfunction

  function automatic void make_recent(int s, int unsigned lim);
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (i != s && mvld[i] && mage[i] < lim) mage[i]++;
    mage[s] = 0;
  endfunction

  function automatic lookup_result_t lru_access(op_word_t w);
    lookup_result_t r;
    int found;
    int slot;
    int unsigned cap;
    found = -1;
    slot = -1;
    cap = (mcap == 0) ? 1 : (mcap > MAX_ENTRIES ? MAX_ENTRIES : mcap);
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (found < 0 && mvld[i] && mkey[i] == w.key) found = i;
    r.hit = (found >= 0);
    r.rdata = '0;
    if (w.op == OP_GET) begin
      if (found >= 0) begin
        r.rdata = mval[found];
        make_recent(found, mage[found]);
      end else begin
        r.rdata = '1;
      end
    end else if (found >= 0) begin
      mval[found] = w.val;
      make_recent(found, mage[found]);
    end else begin
      if (mocc >= cap) begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot < 0 && mvld[i] && mage[i] + 1 >= mocc) slot = i;
      end else begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot < 0 && !mvld[i]) slot = i;
        if (slot >= 0) mocc++;
      end
      if (slot >= 0) begin
        mkey[slot] = w.key;
        mval[slot] = w.val;
        mvld[slot] = 1'b1;
        make_recent(slot, MAX_ENTRIES);
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_operation <= w.op;
          in_key <= w.key;
          in_put_value <= w.val;
          expected_results.push_back(lru_access(w));
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: hit %b value %h",
                 $time, out_hit, out_read_value);
        failed = 1;
      end else begin
        lookup_result_t e;
        e = expected_results.pop_front();
        if (out_hit !== e.hit) begin
          $display("%0t: hit expected %b actual %b", $time, e.hit, out_hit);
          failed = 1;
        end
        if (out_read_value !== e.rdata) begin
          $display("%0t: read_value expected %h actual %h", $time, e.rdata,
                   out_read_value);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("** lru_key_value_cache_core: FAILED **");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    // small key pool keeps hits and evictions frequent
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(7);
      default: return $urandom_range(23);
    endcase
  endfunction

  task automatic queue_word(logic [0:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    op_word_t w;
    w.op = op;
    w.key = k;
    w.val = v;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    wait (pending_words.size() == 0);
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mcap = c;
    empty_store();
  endtask

  initial begin
    logic [CAP_W-1:0] caps [8];
    caps = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd4, 5'd16, 5'd8, 5'd17};
    mcap = CAP_RESET;
    empty_store();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, miss, hit, update, eviction at full capacity 16
    queue_word(OP_GET, 32'h0, 32'h0);
    queue_word(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_word(OP_GET, 32'h8000_0000, 32'h1234_5678);
    queue_word(OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_word(OP_GET, 32'h7FFF_FFFF, 32'h0);
    queue_word(OP_GET, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 16; i++) queue_word(OP_PUT, i, ~i);
    queue_word(OP_GET, 32'h8000_0000, 32'h0);
    queue_word(OP_GET, 32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_capacity(caps[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int n = 0; n < 250; n++)
        queue_word(1'($urandom_range(1)), pick_key(), $urandom());
      drain();
    end

    if (!failed) begin
      $display("** lru_key_value_cache_core: PASSED **");
    end else begin
      $display("** lru_key_value_cache_core: FAILED **");
    end
    $finish;
  end

endmodule
